// ----- hw/rtl/chunked_sparse_tile_store_defines.svh -----
// Assertion helpers for the tile store; clk and rst are taken from the using scope.
`ifndef CHUNKED_SPARSE_TILE_STORE_DEFINES_SVH
`define CHUNKED_SPARSE_TILE_STORE_DEFINES_SVH

// Same-cycle implication.
`define CST_CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CST_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/cst_pkg.sv -----
package cst_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_CHUNKS_DEF      = 64;
  localparam int MAX_CHUNK_SHIFT_DEF = 4;
  localparam int TILE_BITS_DEF       = 8;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 7;

  localparam logic [CFG_INDEX_W-1:0] REG_CHUNK_SHIFT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CHUNKS_X    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CHUNKS_Y    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CHUNKS_Z    = 2'd3;

  localparam logic [2:0] CHUNK_SHIFT_RST = 3'd4;
  localparam logic [6:0] CHUNK_COUNT_RST = 7'd1;

  // Tile values reported as empty
  localparam int EMPTY_VAL_A = 1;
  localparam int EMPTY_VAL_B = 3;
  localparam int EMPTY_VAL_C = 4;

  // Value written over a freshly allocated chunk
  localparam int FILL_VAL = 1;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  // Chunk split of one request, handed from the index unit to the sequencer
  typedef struct packed {
    logic        cx_ok;
    logic        cy_ok;
    logic        cz_ok;
    logic [6:0]  cx;
    logic [5:0]  cz;
    logic [13:0] cyx;      // cy * chunks_x
    logic [13:0] prod_xy;  // chunks_x * chunks_y
  } split_t;

endpackage

// ----- hw/rtl/cst_if.sv -----
interface cst_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] abs_tile_x;
  logic [15:0] abs_tile_y;
  logic [5:0]  abs_tile_z;
  logic [7:0]  write_value;

  modport source (output valid, opcode, abs_tile_x, abs_tile_y, abs_tile_z, write_value,
                  input ready);
  modport sink   (input valid, opcode, abs_tile_x, abs_tile_y, abs_tile_z, write_value,
                  output ready);
endinterface

interface cst_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] tile_value;
  logic       is_empty;
  logic       in_range;
  logic       chunk_allocated;

  modport source (output valid, tile_value, is_empty, in_range, chunk_allocated,
                  input ready);
  modport sink   (input valid, tile_value, is_empty, in_range, chunk_allocated,
                  output ready);
endinterface

// ----- hw/rtl/cst_index.sv -----
module cst_index #(
  parameter int MAX_CHUNK_SHIFT = cst_pkg::MAX_CHUNK_SHIFT_DEF
) (
  input  logic [2:0]                 chunk_shift,
  input  logic [6:0]                 chunks_x,
  input  logic [6:0]                 chunks_y,
  input  logic [6:0]                 chunks_z,
  input  logic [15:0]                abs_tile_x,
  input  logic [15:0]                abs_tile_y,
  input  logic [5:0]                 abs_tile_z,
  output cst_pkg::split_t            split,
  output logic [MAX_CHUNK_SHIFT-1:0] rx,
  output logic [MAX_CHUNK_SHIFT-1:0] ry
);

  localparam int SH_W = $clog2(MAX_CHUNK_SHIFT + 1);

  logic [SH_W-1:0]            sh;
  logic [MAX_CHUNK_SHIFT-1:0] mask;
  logic [15:0]                cx_full;
  logic [15:0]                cy_full;

  // shift saturates at the slot side
  always_comb begin
    if (32'(chunk_shift) > MAX_CHUNK_SHIFT) begin
      sh = SH_W'(MAX_CHUNK_SHIFT);
    end else begin
      sh = SH_W'(chunk_shift);
    end
  end

  assign mask    = MAX_CHUNK_SHIFT'((32'd1 << sh) - 32'd1);
  assign cx_full = abs_tile_x >> sh;
  assign cy_full = abs_tile_y >> sh;
  assign rx      = abs_tile_x[MAX_CHUNK_SHIFT-1:0] & mask;
  assign ry      = abs_tile_y[MAX_CHUNK_SHIFT-1:0] & mask;

  assign split.cx_ok   = cx_full < 16'(chunks_x);
  assign split.cy_ok   = cy_full < 16'(chunks_y);
  assign split.cz_ok   = 7'(abs_tile_z) < chunks_z;
  assign split.cx      = cx_full[6:0];
  assign split.cz      = abs_tile_z;
  // low bits suffice: only used once cy < chunks_y
  assign split.cyx     = 14'(cy_full[6:0]) * 14'(chunks_x);
  assign split.prod_xy = 14'(chunks_x) * 14'(chunks_y);

endmodule

// ----- hw/rtl/chunked_sparse_tile_store.sv -----
// Sparse tile map of square chunks. Each request reads or writes one tile at an
// absolute (x, y, z); x and y are split by the configured chunk shift (saturated at
// MAX_CHUNK_SHIFT) into chunk and in-chunk coordinates, z is the chunk layer. The
// chunk must lie inside chunks_x/y/z and the count product must not exceed
// MAX_CHUNKS, else the request is out of range: a read returns 0, a write is
// dropped. One response per request. A request is taken only while the sequencer
// is idle; it then passes through calculate (index multiply plus tile memory read)
// and done (response register load), so with a free output a request occupies the
// states idle/accept, calculate, done. The first write to a chunk also sweeps its
// 2**(2*MAX_CHUNK_SHIFT) tiles to 1 through the single memory write port, one tile
// a cycle. A new request is accepted while an earlier response still waits; a
// stalled response holds the sequencer in its final state. Chunk allocation bits
// clear at reset; tile memory needs no clearing pass, as a chunk is only read once
// fully filled.
// Configuration may be written only while idle; stored chunks survive a change.
`include "chunked_sparse_tile_store_defines.svh"

module chunked_sparse_tile_store #(
  parameter int MAX_CHUNKS      = cst_pkg::MAX_CHUNKS_DEF,
  parameter int MAX_CHUNK_SHIFT = cst_pkg::MAX_CHUNK_SHIFT_DEF,
  parameter int TILE_BITS       = cst_pkg::TILE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [cst_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cst_pkg::CFG_DATA_W-1:0]  cfg_data,
  cst_req_if.sink                        req,
  cst_rsp_if.source                      rsp
);

  localparam int IDX_W     = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int OFF_W     = 2 * MAX_CHUNK_SHIFT;
  localparam int ADDR_W    = IDX_W + OFF_W;
  localparam int MEM_DEPTH = MAX_CHUNKS * (2 ** OFF_W);

  // one-hot sequencer
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CALC = 4'b0010,
    S_FILL = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // configuration registers
  logic [2:0] chunk_shift;
  logic [6:0] chunks_x;
  logic [6:0] chunks_y;
  logic [6:0] chunks_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_shift <= cst_pkg::CHUNK_SHIFT_RST;
      chunks_x    <= cst_pkg::CHUNK_COUNT_RST;
      chunks_y    <= cst_pkg::CHUNK_COUNT_RST;
      chunks_z    <= cst_pkg::CHUNK_COUNT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        cst_pkg::REG_CHUNK_SHIFT: chunk_shift <= cfg_data[2:0];
        cst_pkg::REG_CHUNKS_X:    chunks_x    <= cfg_data;
        cst_pkg::REG_CHUNKS_Y:    chunks_y    <= cfg_data;
        cst_pkg::REG_CHUNKS_Z:    chunks_z    <= cfg_data;
      endcase
    end
  end

  // ---- stage 1: chunk split, taken at acceptance ----
  cst_pkg::split_t            split_c;
  logic [MAX_CHUNK_SHIFT-1:0] rx_c;
  logic [MAX_CHUNK_SHIFT-1:0] ry_c;

  cst_index #(.MAX_CHUNK_SHIFT(MAX_CHUNK_SHIFT)) u_index (
    .chunk_shift (chunk_shift),
    .chunks_x    (chunks_x),
    .chunks_y    (chunks_y),
    .chunks_z    (chunks_z),
    .abs_tile_x  (req.abs_tile_x),
    .abs_tile_y  (req.abs_tile_y),
    .abs_tile_z  (req.abs_tile_z),
    .split       (split_c),
    .rx          (rx_c),
    .ry          (ry_c)
  );

  logic accept;
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  // job registers (payload, no reset)
  cst_pkg::op_t               job_op;
  logic [7:0]                 job_wv;
  cst_pkg::split_t            job;
  logic [MAX_CHUNK_SHIFT-1:0] job_rx;
  logic [MAX_CHUNK_SHIFT-1:0] job_ry;
  logic [IDX_W-1:0]           job_idx;
  logic                       job_rng;
  logic                       job_v;    // in range and chunk allocated

  // ---- stage 2: linear chunk index and bounds ----
  logic [20:0]      prod_c;
  logic [20:0]      idx_full_c;
  logic [IDX_W-1:0] idx_c;
  logic             rng_c;
  logic             v_c;

  assign prod_c     = 21'(job.prod_xy) * 21'(chunks_z);
  assign idx_full_c = 21'(job.cz) * 21'(job.prod_xy) + 21'(job.cyx) + 21'(job.cx);
  // in range implies idx < product <= MAX_CHUNKS, so the low bits are exact
  assign idx_c      = idx_full_c[IDX_W-1:0];
  assign rng_c      = job.cx_ok && job.cy_ok && job.cz_ok && (prod_c <= 21'(MAX_CHUNKS));

  logic [MAX_CHUNKS-1:0] chunk_valid;
  assign v_c = rng_c && chunk_valid[idx_c];

  // fill sweep over one chunk slot
  logic [OFF_W-1:0] fill_cnt;

  // output register
  logic out_free;
  logic load;
  assign out_free = !rsp.valid || rsp.ready;
  assign load     = (state == S_DONE) && out_free;

  // ---- tile memory: one write port, one registered read port ----
  logic [TILE_BITS-1:0] tile_mem [MEM_DEPTH];
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [TILE_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [ADDR_W-1:0]    mem_raddr;
  logic [TILE_BITS-1:0] mem_rdata;

  // Reads issue in S_CALC and writes land in S_FILL/S_DONE, so one request's write
  // always completes before the next request's read; no forwarding is needed.
  assign mem_we    = (state == S_FILL) || (load && job_op == cst_pkg::OP_WRITE && job_rng);
  assign mem_waddr = (state == S_FILL) ? {job_idx, fill_cnt} : {job_idx, job_ry, job_rx};
  assign mem_wdata = (state == S_FILL) ? TILE_BITS'(cst_pkg::FILL_VAL) : TILE_BITS'(job_wv);
  assign mem_re    = (state == S_CALC) && (job_op == cst_pkg::OP_READ) && v_c;
  assign mem_raddr = {idx_c, job_ry, job_rx};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tile_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= tile_mem[mem_raddr];
    end
  end

  // ---- sequencer ----
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_CALC;
      end
      S_CALC: begin
        if (job_op == cst_pkg::OP_WRITE && rng_c && !v_c) state_next = S_FILL;
        else state_next = S_DONE;
      end
      S_FILL: begin
        if (fill_cnt == '1) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_op <= cst_pkg::op_t'(req.opcode);
      job_wv <= req.write_value;
      job    <= split_c;
      job_rx <= rx_c;
      job_ry <= ry_c;
    end
    if (state == S_CALC) begin
      job_idx  <= idx_c;
      job_rng  <= rng_c;
      job_v    <= v_c;
      fill_cnt <= '0;
    end else if (state == S_FILL) begin
      fill_cnt <= fill_cnt + 1'b1;
    end
  end

  // allocation bits
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_valid <= '0;
    end else if (load && job_op == cst_pkg::OP_WRITE && job_rng) begin
      chunk_valid[job_idx] <= 1'b1;
    end
  end

  // ---- response ----
  logic rd_empty;
  assign rd_empty = (mem_rdata == TILE_BITS'(cst_pkg::EMPTY_VAL_A)) ||
                    (mem_rdata == TILE_BITS'(cst_pkg::EMPTY_VAL_B)) ||
                    (mem_rdata == TILE_BITS'(cst_pkg::EMPTY_VAL_C));

  logic rsp_valid;
  assign rsp.valid = rsp_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.in_range <= job_rng;
      if (job_op == cst_pkg::OP_WRITE) begin
        rsp.tile_value      <= 8'd0;
        rsp.is_empty        <= 1'b0;
        rsp.chunk_allocated <= job_rng;
      end else begin
        rsp.tile_value      <= job_v ? 8'(mem_rdata) : 8'd0;
        rsp.is_empty        <= job_v && rd_empty;
        rsp.chunk_allocated <= job_v;
      end
    end
  end

  // ---- checks ----
  `CST_CHECK_NOW(a_fill_only_new_chunk, state == S_FILL,
    job_op == cst_pkg::OP_WRITE && job_rng && !job_v, "fill on a read or allocated chunk")
  `CST_CHECK_NEXT(a_alloc_after_write, mem_we && state == S_DONE,
    chunk_valid[job_idx], "chunk not marked allocated after write")
  `CST_CHECK_NOW(a_alloc_in_range, rsp.valid && rsp.chunk_allocated,
    rsp.in_range, "allocated response outside range")

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

  // Tiles held by one chunk slot, whatever the configured shift
  localparam int SLOT_TILES    = 1 << (2 * cst_pkg::MAX_CHUNK_SHIFT_DEF);
  localparam int LIMIT_CYCLES  = 3_000_000;
  localparam int RANDOM_REQS   = 1230;
  // One full chunk sweep plus the short pipeline, with margin
  localparam int SETTLE_CYCLES = 300;

  typedef struct packed {
    logic [7:0] tile_value;
    logic       is_empty;
    logic       in_range;
    logic       chunk_allocated;
  } tile_rsp_t;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            cfg_wr_en;
  logic [cst_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [cst_pkg::CFG_DATA_W-1:0]  cfg_data;

  cst_req_if tile_req ();
  cst_rsp_if tile_rsp ();

  chunked_sparse_tile_store dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (tile_req),
    .rsp       (tile_rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mirror of the block: configuration as last written, allocation bits and
  // tile slots. Only the monitor below touches these.
  logic [2:0] mirror_shift;
  logic [6:0] mirror_nx, mirror_ny, mirror_nz;
  logic [7:0] mirror_tiles [SLOT_TILES * cst_pkg::MAX_CHUNKS_DEF];
  logic       mirror_live  [cst_pkg::MAX_CHUNKS_DEF];

  tile_rsp_t   pending_rsp_q [$];
  int unsigned reqs_sent  = 0;
  int unsigned rsps_seen  = 0;
  int unsigned fail_count = 0;

  // Stimulus side's own view of the configuration, used to aim requests
  logic [2:0] plan_shift;
  logic [6:0] plan_nx, plan_ny, plan_nz;
  // No random gaps or stalls on either side while set
  bit calm = 1'b0;

  // Works out the response to one request and applies its side effects
  // (chunk allocation with fill, tile store) to the mirror.
  function automatic tile_rsp_t lookup_tile(cst_pkg::op_t op, logic [15:0] ax,
                                            logic [15:0] ay, logic [5:0] az,
                                            logic [7:0] wv);
    tile_rsp_t   res;
    int unsigned sh, cx, cy, rx, ry, volume, idx, base, t;
    res = '0;
    // shifts above the slot size saturate
    sh  = (mirror_shift > cst_pkg::MAX_CHUNK_SHIFT_DEF) ? cst_pkg::MAX_CHUNK_SHIFT_DEF
                                                         : mirror_shift;
    cx  = ax >> sh;
    cy  = ay >> sh;
    rx  = ax & ((1 << sh) - 1);
    ry  = ay & ((1 << sh) - 1);
    volume = mirror_nx;
    volume = volume * mirror_ny * mirror_nz;
    res.in_range = cx < mirror_nx && cy < mirror_ny && az < mirror_nz &&
                   volume <= cst_pkg::MAX_CHUNKS_DEF;
    if (res.in_range) begin
      idx  = az * mirror_ny * mirror_nx + cy * mirror_nx + cx;
      base = idx * SLOT_TILES;
      if (op == cst_pkg::OP_WRITE) begin
        // first write to a chunk fills the whole slot before the store
        if (!mirror_live[idx]) begin
          for (t = 0; t < SLOT_TILES; t++) mirror_tiles[base + t] = 8'(cst_pkg::FILL_VAL);
          mirror_live[idx] = 1'b1;
        end
        mirror_tiles[base + (ry << cst_pkg::MAX_CHUNK_SHIFT_DEF) + rx] = wv;
        res.chunk_allocated = 1'b1;
      end else if (mirror_live[idx]) begin
        res.tile_value      = mirror_tiles[base + (ry << cst_pkg::MAX_CHUNK_SHIFT_DEF) + rx];
        res.is_empty        = res.tile_value == 8'(cst_pkg::EMPTY_VAL_A) ||
                              res.tile_value == 8'(cst_pkg::EMPTY_VAL_B) ||
                              res.tile_value == 8'(cst_pkg::EMPTY_VAL_C);
        res.chunk_allocated = 1'b1;
      end
      // read of an absent chunk: all zero bar in_range
    end
    return res;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Mostly no gap, some short ones, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Monitor: config writes, accepted requests and accepted responses are all
  // sampled here, in one process, so their relative order is fixed.
  always @(posedge clk) begin
    tile_rsp_t want;
    if (rst) begin
      mirror_shift = cst_pkg::CHUNK_SHIFT_RST;
      mirror_nx    = cst_pkg::CHUNK_COUNT_RST;
      mirror_ny    = cst_pkg::CHUNK_COUNT_RST;
      mirror_nz    = cst_pkg::CHUNK_COUNT_RST;
      foreach (mirror_live[i]) mirror_live[i] = 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          cst_pkg::REG_CHUNK_SHIFT: mirror_shift = cfg_data[2:0];
          cst_pkg::REG_CHUNKS_X:    mirror_nx    = cfg_data;
          cst_pkg::REG_CHUNKS_Y:    mirror_ny    = cfg_data;
          cst_pkg::REG_CHUNKS_Z:    mirror_nz    = cfg_data;
          default: ;
        endcase
      end
      if (tile_req.valid && tile_req.ready)
        pending_rsp_q.push_back(lookup_tile(cst_pkg::op_t'(tile_req.opcode),
                                            tile_req.abs_tile_x, tile_req.abs_tile_y,
                                            tile_req.abs_tile_z, tile_req.write_value));
      if (tile_rsp.valid && tile_rsp.ready) begin
        rsps_seen++;
        if (pending_rsp_q.size() == 0) begin
          $error("response with nothing expected: tile_value %0d", tile_rsp.tile_value);
          fail_count++;
        end else begin
          want = pending_rsp_q.pop_front();
          check_field("tile_value", want.tile_value, tile_rsp.tile_value);
          check_field("is_empty", 8'(want.is_empty), 8'(tile_rsp.is_empty));
          check_field("in_range", 8'(want.in_range), 8'(tile_rsp.in_range));
          check_field("chunk_allocated", 8'(want.chunk_allocated),
                      8'(tile_rsp.chunk_allocated));
        end
      end
    end
  end

  // Response side back-pressure: random stalls, none while calm
  initial begin
    int stall_left;
    stall_left = 0;
    tile_rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        tile_rsp.ready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        tile_rsp.ready <= 1'b0;
        stall_left = pick_gap();
      end else begin
        tile_rsp.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Sends one request. valid is left high after acceptance: the caller either
  // follows with another request or lowers it in the same step.
  task automatic send_req(cst_pkg::op_t op, logic [15:0] ax, logic [15:0] ay,
                          logic [5:0] az, logic [7:0] wv);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      tile_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tile_req.valid       <= 1'b1;
    tile_req.opcode      <= op;
    tile_req.abs_tile_x  <= ax;
    tile_req.abs_tile_y  <= ay;
    tile_req.abs_tile_z  <= az;
    tile_req.write_value <= wv;
    @(posedge clk);
    while (!tile_req.ready) @(posedge clk);
    reqs_sent++;
  endtask

  // Holds off the request side until every response is back
  task automatic wait_drained();
    tile_req.valid <= 1'b0;
    while (rsps_seen < reqs_sent) @(posedge clk);
  endtask

  task automatic write_reg(logic [cst_pkg::CFG_INDEX_W-1:0] idx,
                           logic [cst_pkg::CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Reconfigure only once idle; upper bits of the shift data are don't-care
  task automatic apply_config(logic [6:0] shift_data, logic [6:0] nx, logic [6:0] ny,
                              logic [6:0] nz);
    wait_drained();
    write_reg(cst_pkg::REG_CHUNK_SHIFT, shift_data);
    write_reg(cst_pkg::REG_CHUNKS_X, nx);
    write_reg(cst_pkg::REG_CHUNKS_Y, ny);
    write_reg(cst_pkg::REG_CHUNKS_Z, nz);
    cfg_wr_en  <= 1'b0;
    plan_shift = shift_data[2:0];
    plan_nx    = nx;
    plan_ny    = ny;
    plan_nz    = nz;
  endtask

  // Reset configuration: one 16x16 chunk. Absent chunk, out of range on x and
  // z, allocation fill, the empty values and a plain zero.
  task automatic test_reset_config();
    send_req(cst_pkg::OP_READ,  16'd0,  16'd0,  6'd0, 8'hFF);
    send_req(cst_pkg::OP_READ,  16'd16, 16'd0,  6'd0, 8'h00);
    send_req(cst_pkg::OP_READ,  16'd0,  16'd0,  6'd1, 8'h00);
    send_req(cst_pkg::OP_WRITE, 16'd5,  16'd7,  6'd0, 8'hAB);
    send_req(cst_pkg::OP_READ,  16'd0,  16'd0,  6'd0, 8'h00);
    send_req(cst_pkg::OP_READ,  16'd5,  16'd7,  6'd0, 8'h00);
    send_req(cst_pkg::OP_WRITE, 16'd15, 16'd15, 6'd0, 8'd3);
    send_req(cst_pkg::OP_READ,  16'd15, 16'd15, 6'd0, 8'h00);
    send_req(cst_pkg::OP_WRITE, 16'd1,  16'd0,  6'd0, 8'd4);
    send_req(cst_pkg::OP_READ,  16'd1,  16'd0,  6'd0, 8'h00);
    send_req(cst_pkg::OP_WRITE, 16'd2,  16'd0,  6'd0, 8'd0);
    send_req(cst_pkg::OP_READ,  16'd2,  16'd0,  6'd0, 8'h00);
  endtask

  // Unit chunks, 64 along x: top chunk, then all-ones fields (write dropped)
  task automatic test_field_extremes();
    apply_config(7'd0, 7'd64, 7'd1, 7'd1);
    send_req(cst_pkg::OP_WRITE, 16'd63,    16'd0,    6'd0,  8'hFF);
    send_req(cst_pkg::OP_READ,  16'd63,    16'd0,    6'd0,  8'h00);
    send_req(cst_pkg::OP_WRITE, 16'hFFFF,  16'hFFFF, 6'h3F, 8'hFF);
    send_req(cst_pkg::OP_READ,  16'hFFFF,  16'hFFFF, 6'h3F, 8'h00);
  endtask

  // Saturating shift, oversized product, zero count, and chunks kept across
  // a change of shape.
  task automatic test_config_corners();
    apply_config(7'h7F, 7'd1, 7'd1, 7'd64);
    send_req(cst_pkg::OP_WRITE, 16'd15, 16'd15, 6'd63, 8'h5A);
    send_req(cst_pkg::OP_READ,  16'd15, 16'd15, 6'd63, 8'h00);
    send_req(cst_pkg::OP_READ,  16'd16, 16'd0,  6'd63, 8'h00);
    apply_config(7'd4, 7'd8, 7'd8, 7'd2);
    send_req(cst_pkg::OP_READ,  16'd0,  16'd0,  6'd0,  8'h00);
    apply_config(7'd4, 7'd0, 7'd1, 7'd1);
    send_req(cst_pkg::OP_WRITE, 16'd0,  16'd0,  6'd0,  8'd1);
    apply_config(7'd4, 7'd1, 7'd1, 7'd1);
    send_req(cst_pkg::OP_READ,  16'd5,  16'd7,  6'd0,  8'h00);
  endtask

  // Phases of random traffic, each under its own configuration. Most requests
  // aim inside the configured map so reads hit allocated chunks; the rest are
  // edge-of-map or fully random coordinates.
  task automatic test_random_traffic();
    int unsigned  issued, phase_len, hold_at, n, eff, side, cxi, cyi, czi, span;
    bit           aimable;
    cst_pkg::op_t op;
    logic [15:0]  ax, ay;
    logic [5:0]   az;
    logic [7:0]   wv;
    logic [6:0]   nx, ny, nz;
    issued = 0;
    while (issued < RANDOM_REQS) begin
      case ($urandom_range(0, 9))
        0: begin
          // long thin, flat or cubic shapes at the chunk limit
          case ($urandom_range(0, 4))
            0: {nx, ny, nz} = {7'd64, 7'd1,  7'd1};
            1: {nx, ny, nz} = {7'd1,  7'd64, 7'd1};
            2: {nx, ny, nz} = {7'd1,  7'd1,  7'd64};
            3: {nx, ny, nz} = {7'd8,  7'd8,  7'd1};
            default: {nx, ny, nz} = {7'd4, 7'd4, 7'd4};
          endcase
        end
        1: begin
          // shapes under which nothing is in range
          case ($urandom_range(0, 3))
            0: {nx, ny, nz} = {7'd0, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127))};
            1: {nx, ny, nz} = {7'd1, 7'd1, 7'd0};
            2: {nx, ny, nz} = {7'd127, 7'd127, 7'd127};
            default: {nx, ny, nz} = {7'($urandom_range(9, 127)), 7'($urandom_range(8, 127)),
                                     7'($urandom_range(1, 127))};
          endcase
        end
        default: begin
          nz = 7'($urandom_range(1, 4));
          ny = 7'($urandom_range(1, 4));
          nx = 7'($urandom_range(1, 64 / (ny * nz)));
        end
      endcase
      calm = ($urandom_range(0, 4) == 0);
      apply_config(7'($urandom_range(0, 127)), nx, ny, nz);

      span    = plan_nx * plan_ny * plan_nz;
      aimable = plan_nx != 0 && plan_ny != 0 && plan_nz != 0 &&
                span <= cst_pkg::MAX_CHUNKS_DEF;
      eff     = (plan_shift > cst_pkg::MAX_CHUNK_SHIFT_DEF) ? cst_pkg::MAX_CHUNK_SHIFT_DEF
                                                             : plan_shift;
      side    = 1 << eff;

      phase_len = $urandom_range(40, 120);
      if (phase_len > RANDOM_REQS - issued) phase_len = RANDOM_REQS - issued;
      hold_at   = $urandom_range(1, phase_len - 1);
      for (n = 0; n < phase_len; n++) begin
        // mid-phase pause until the block has answered everything
        if (n == hold_at) wait_drained();
        op = ($urandom_range(0, 9) < 4) ? cst_pkg::OP_WRITE : cst_pkg::OP_READ;
        wv = 8'($urandom);
        if ($urandom_range(0, 3) == 0) wv = 8'($urandom_range(0, 5));
        if (aimable && $urandom_range(0, 9) < 8) begin
          cxi = $urandom_range(0, plan_nx - 1);
          cyi = $urandom_range(0, plan_ny - 1);
          czi = $urandom_range(0, plan_nz - 1);
          // now and then step one chunk past the edge
          case ($urandom_range(0, 29))
            0: cxi = plan_nx;
            1: cyi = plan_ny;
            2: czi = plan_nz;
            default: ;
          endcase
          ax = 16'((cxi << eff) | $urandom_range(0, side - 1));
          ay = 16'((cyi << eff) | $urandom_range(0, side - 1));
          az = 6'(czi);
        end else begin
          ax = 16'($urandom);
          ay = 16'($urandom);
          az = 6'($urandom);
        end
        send_req(op, ax, ay, az, wv);
        issued++;
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    rst                  <= 1'b1;
    cfg_wr_en            <= 1'b0;
    cfg_index            <= cst_pkg::REG_CHUNK_SHIFT;
    cfg_data             <= '0;
    tile_req.valid       <= 1'b0;
    tile_req.opcode      <= cst_pkg::OP_READ;
    tile_req.abs_tile_x  <= '0;
    tile_req.abs_tile_y  <= '0;
    tile_req.abs_tile_z  <= '0;
    tile_req.write_value <= '0;
    plan_shift = cst_pkg::CHUNK_SHIFT_RST;
    plan_nx    = cst_pkg::CHUNK_COUNT_RST;
    plan_ny    = cst_pkg::CHUNK_COUNT_RST;
    plan_nz    = cst_pkg::CHUNK_COUNT_RST;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_config();
    test_field_extremes();
    test_config_corners();
    test_random_traffic();

    // let any stray response show up before the verdict
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_rsp_q.size() != 0) begin
      $error("%0d expected responses never arrived", pending_rsp_q.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/cst_pkg.sv
hw/rtl/cst_if.sv
hw/rtl/cst_index.sv
hw/rtl/chunked_sparse_tile_store.sv
tb/sv/tb_top.sv
